// File: rtl/rti_pkg.sv
// Shared types and constants for the ray/triangle intersection unit.
// Holds the request, response, ray register and queue entry types.
// No dependencies.
`default_nettype none

package rti_pkg;

   localparam int COORD_W       = 32;
   localparam int EPS_W         = 31;
   localparam int DIST_W        = 31;
   localparam int FRAC_BITS_DEF = 16;

   // exact triple products: (W+1) x (2W+2) terms summed three at a time
   localparam int DW = 3 * COORD_W + 4;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON  = 3'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [COORD_W-1:0] vert_x;
      logic [COORD_W-1:0] vert_y;
      logic [COORD_W-1:0] vert_z;
      logic [COORD_W-1:0] edge_a_x;
      logic [COORD_W-1:0] edge_a_y;
      logic [COORD_W-1:0] edge_a_z;
      logic [COORD_W-1:0] edge_b_x;
      logic [COORD_W-1:0] edge_b_y;
      logic [COORD_W-1:0] edge_b_z;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] distance;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] origin_z;
      logic [COORD_W-1:0] dir_x;
      logic [COORD_W-1:0] dir_y;
      logic [COORD_W-1:0] dir_z;
   } ray_type;

   typedef struct packed {
      logic          miss;
      logic          sat;
      logic [DW-1:0] tn;
      logic [DW-1:0] dabs;
   } qent_type;

endpackage

`default_nettype wire

// File: rtl/ray_triangle_intersect_unit.sv
// A result strobes once its transfer has passed the 8-stage front, the queue,
// the 31-step divider and the response register. Throughput: one triangle per
// cycle while busy is low. Reset (synchronous) loads origin 0, direction (0,0,1.0),
// epsilon 1 and empties the pipeline; results are never held off by the receiver.
// Top level: ray registers, front, queue and back. Depends on rti_pkg.
`default_nettype none

module ray_triangle_intersect_unit #(
   parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire rti_pkg::req_type                req_item,
   output logic                                 rsp_strobe,
   output rti_pkg::rsp_type                     rsp_item,
   input  wire logic                            csr_we,
   input  wire logic [rti_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rti_pkg::COORD_W-1:0]     csr_wdata
);

   localparam int CW = rti_pkg::COORD_W;
   localparam int EW = rti_pkg::EPS_W;

   rti_pkg::ray_type  ray_ff, ray_in;
   logic [EW-1:0]     eps_ff, eps_in;

   logic              front_valid;
   rti_pkg::qent_type front_entry;
   logic              q_full;
   logic              q_valid;
   rti_pkg::qent_type q_entry;

   always_comb begin
      ray_in = ray_ff;
      eps_in = eps_ff;
      if (csr_we) begin
         case (csr_index)
            rti_pkg::CSR_ORIGIN_X: ray_in.origin_x = csr_wdata;
            rti_pkg::CSR_ORIGIN_Y: ray_in.origin_y = csr_wdata;
            rti_pkg::CSR_ORIGIN_Z: ray_in.origin_z = csr_wdata;
            rti_pkg::CSR_DIR_X:    ray_in.dir_x    = csr_wdata;
            rti_pkg::CSR_DIR_Y:    ray_in.dir_y    = csr_wdata;
            rti_pkg::CSR_DIR_Z:    ray_in.dir_z    = csr_wdata;
            rti_pkg::CSR_EPSILON:  eps_in          = csr_wdata[EW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff.origin_x <= '0;
         ray_ff.origin_y <= '0;
         ray_ff.origin_z <= '0;
         ray_ff.dir_x    <= '0;
         ray_ff.dir_y    <= '0;
         ray_ff.dir_z    <= CW'(1) << FRAC_BITS;
         eps_ff          <= EW'(1);
      end else begin
         ray_ff <= ray_in;
         eps_ff <= eps_in;
      end
   end

   assign busy = q_full;

   rti_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_item   (req_item),
      .ray       (ray_ff),
      .eps       (eps_ff),
      .out_valid (front_valid),
      .out_entry (front_entry)
   );

   rti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_entry (front_entry),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_entry  (q_entry)
   );

   rti_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_entry   (q_entry),
      .eps        (eps_ff),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.hit |-> rsp_item.distance == '0)
      else $error("miss with nonzero distance");

   a_hit_beyond_eps: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.hit |-> rsp_item.distance > eps_ff)
      else $error("hit at or below epsilon");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      !q_full)
      else $error("queue filled although the back end drains every cycle");

endmodule

`default_nettype wire

// File: rtl/rti_front.sv
// Front pipeline: cross products, exact dot products, sign fix and classification.
// Eight stages, one triangle per cycle. Depends on rti_pkg.
`default_nettype none

module rti_front #(
   parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   input  wire rti_pkg::req_type            in_item,
   input  wire rti_pkg::ray_type            ray,
   input  wire logic [rti_pkg::EPS_W-1:0]   eps,
   output logic                             out_valid,
   output rti_pkg::qent_type                out_entry
);

   localparam int W    = rti_pkg::COORD_W;
   localparam int AW   = W + 1;
   localparam int BW   = 2 * W + 2;
   localparam int PW   = 2 * AW;
   localparam int HW   = AW + W + 2;
   localparam int DW   = rti_pkg::DW;
   localparam int STG  = 8;
   localparam int EL   = rti_pkg::EPS_W + 2 * FRAC_BITS;
   localparam int CMPW = ((DW > EL) ? DW : EL) + 1;
   localparam int SW   = DW + 32 + FRAC_BITS;

   logic signed [W-1:0]  org_v [3];
   logic signed [W-1:0]  dir_v [3];
   logic signed [W-1:0]  vert_v [3];
   logic signed [W-1:0]  ea_v [3];
   logic signed [W-1:0]  eb_v [3];
   logic signed [AW-1:0] dir_ext [3];
   logic signed [AW-1:0] tv_in [3];

   logic signed [AW-1:0] tv_ff [3][3];
   logic signed [AW-1:0] e1_ff [3][3];
   logic signed [AW-1:0] e2_ff [3][3];
   logic signed [BW-1:0] pm1_ff [3];
   logic signed [BW-1:0] pm2_ff [3];
   logic signed [BW-1:0] qm1_ff [3];
   logic signed [BW-1:0] qm2_ff [3];
   logic signed [BW-1:0] p_ff [3];
   logic signed [BW-1:0] q_ff [3];

   logic signed [AW-1:0] lop [12];
   logic signed [BW-1:0] rop [12];
   logic signed [PW-1:0] lo_ff [12];
   logic signed [HW-1:0] hi_ff [12];
   logic signed [DW-1:0] term_ff [12];
   logic signed [DW-1:0] sum_ff [4];

   logic [DW-1:0] dabs_ff;
   logic [DW-1:0] un_ff;
   logic [DW-1:0] vn_ff;
   logic [DW-1:0] tn_ff;

   logic [STG-1:0] vld_ff;
   logic [STG-1:0] vld_in;
   rti_pkg::qent_type entry_ff;
   rti_pkg::qent_type entry_in;

   logic              det_neg;
   logic [CMPW-1:0]   eps_lim;
   logic signed [DW:0] un_x;
   logic signed [DW:0] vn_x;
   logic signed [DW:0] uv_x;
   logic signed [DW:0] dabs_x;
   logic [SW-1:0]     num_x;
   logic [SW-1:0]     lim_x;

   assign org_v[0]  = $signed(ray.origin_x);
   assign org_v[1]  = $signed(ray.origin_y);
   assign org_v[2]  = $signed(ray.origin_z);
   assign dir_v[0]  = $signed(ray.dir_x);
   assign dir_v[1]  = $signed(ray.dir_y);
   assign dir_v[2]  = $signed(ray.dir_z);
   assign vert_v[0] = $signed(in_item.vert_x);
   assign vert_v[1] = $signed(in_item.vert_y);
   assign vert_v[2] = $signed(in_item.vert_z);
   assign ea_v[0]   = $signed(in_item.edge_a_x);
   assign ea_v[1]   = $signed(in_item.edge_a_y);
   assign ea_v[2]   = $signed(in_item.edge_a_z);
   assign eb_v[0]   = $signed(in_item.edge_b_x);
   assign eb_v[1]   = $signed(in_item.edge_b_y);
   assign eb_v[2]   = $signed(in_item.edge_b_z);

   for (genvar k = 0; k < 3; k++) begin : g_vec
      localparam int K1 = (k + 1) % 3;
      localparam int K2 = (k + 2) % 3;

      assign tv_in[k]   = AW'(org_v[k]) - AW'(vert_v[k]);
      assign dir_ext[k] = AW'(dir_v[k]);

      always_ff @(posedge clock) begin
         tv_ff[0][k] <= tv_in[k];
         e1_ff[0][k] <= AW'(ea_v[k]);
         e2_ff[0][k] <= AW'(eb_v[k]);
         tv_ff[1][k] <= tv_ff[0][k];
         e1_ff[1][k] <= e1_ff[0][k];
         e2_ff[1][k] <= e2_ff[0][k];
         tv_ff[2][k] <= tv_ff[1][k];
         e1_ff[2][k] <= e1_ff[1][k];
         e2_ff[2][k] <= e2_ff[1][k];
         pm1_ff[k]   <= BW'(dir_ext[K1]) * BW'(e2_ff[0][K2]);
         pm2_ff[k]   <= BW'(dir_ext[K2]) * BW'(e2_ff[0][K1]);
         qm1_ff[k]   <= BW'(tv_ff[0][K1]) * BW'(e1_ff[0][K2]);
         qm2_ff[k]   <= BW'(tv_ff[0][K2]) * BW'(e1_ff[0][K1]);
         p_ff[k]     <= pm1_ff[k] - pm2_ff[k];
         q_ff[k]     <= qm1_ff[k] - qm2_ff[k];
      end

      assign lop[k]     = e1_ff[2][k];
      assign rop[k]     = p_ff[k];
      assign lop[3 + k] = tv_ff[2][k];
      assign rop[3 + k] = p_ff[k];
      assign lop[6 + k] = dir_ext[k];
      assign rop[6 + k] = q_ff[k];
      assign lop[9 + k] = e2_ff[2][k];
      assign rop[9 + k] = q_ff[k];
   end

   for (genvar j = 0; j < 12; j++) begin : g_term
      always_ff @(posedge clock) begin
         lo_ff[j]   <= PW'(lop[j]) * PW'($signed({1'b0, rop[j][W-1:0]}));
         hi_ff[j]   <= HW'(lop[j]) * HW'($signed(rop[j][BW-1:W]));
         term_ff[j] <= (DW'(hi_ff[j]) <<< W) + DW'(lo_ff[j]);
      end
   end

   for (genvar g = 0; g < 4; g++) begin : g_sum
      always_ff @(posedge clock) begin
         sum_ff[g] <= term_ff[3 * g] + term_ff[3 * g + 1] + term_ff[3 * g + 2];
      end
   end

   assign det_neg = sum_ff[0][DW-1];

   always_ff @(posedge clock) begin
      dabs_ff <= det_neg ? -sum_ff[0] : sum_ff[0];
      un_ff   <= det_neg ? -sum_ff[1] : sum_ff[1];
      vn_ff   <= det_neg ? -sum_ff[2] : sum_ff[2];
      tn_ff   <= det_neg ? -sum_ff[3] : sum_ff[3];
   end

   always_comb begin
      eps_lim = CMPW'(eps) << (2 * FRAC_BITS);
      un_x    = (DW + 1)'($signed(un_ff));
      vn_x    = (DW + 1)'($signed(vn_ff));
      uv_x    = un_x + vn_x;
      dabs_x  = $signed({1'b0, dabs_ff});
      num_x   = SW'(tn_ff) << FRAC_BITS;
      lim_x   = SW'(dabs_ff) << 31;
      entry_in.miss = (CMPW'(dabs_ff) < eps_lim) || (dabs_ff == '0)
                      || un_ff[DW-1] || (un_x > dabs_x)
                      || vn_ff[DW-1] || (uv_x > dabs_x)
                      || tn_ff[DW-1] || (tn_ff == '0);
      entry_in.sat  = (num_x >= lim_x);
      entry_in.tn   = tn_ff;
      entry_in.dabs = dabs_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign vld_in = {vld_ff[STG-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign out_valid = vld_ff[STG-1];
   assign out_entry = entry_ff;

endmodule

`default_nettype wire

// File: rtl/rti_queue.sv
// Short queue between the front pipeline and the divider.
// Drains one entry per cycle whenever it holds one. Depends on rti_pkg.
`default_nettype none

module rti_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rti_pkg::qent_type  push_entry,
   output logic                    full,
   output logic                    pop_valid,
   output rti_pkg::qent_type       pop_entry
);

   localparam int D  = rti_pkg::QUEUE_DEPTH;
   localparam int PW = rti_pkg::QPTR_W;
   localparam int CW = rti_pkg::QCNT_W;

   rti_pkg::qent_type mem [D];
   rti_pkg::qent_type pop_entry_ff;

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pop_valid_ff;
   logic          pop;

   assign pop       = (count_ff != '0);
   assign full      = (count_ff == CW'(D));
   assign wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CW'(push) - CW'(pop);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
      if (pop) begin
         pop_entry_ff <= mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         pop_valid_ff <= pop;
      end
   end

   assign pop_valid = pop_valid_ff;
   assign pop_entry = pop_entry_ff;

endmodule

`default_nettype wire

// File: rtl/rti_back.sv
// Back pipeline: restoring divide for the hit distance, one quotient bit per stage,
// then saturation, the epsilon test and the response register. Depends on rti_pkg.
`default_nettype none

module rti_back #(
   parameter int FRAC_BITS = rti_pkg::FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire rti_pkg::qent_type         in_entry,
   input  wire logic [rti_pkg::EPS_W-1:0] eps,
   output logic                           rsp_strobe,
   output rti_pkg::rsp_type               rsp_item
);

   localparam int DW  = rti_pkg::DW;
   localparam int QW  = rti_pkg::DIST_W;
   localparam int NW  = DW + 32 + FRAC_BITS;
   localparam int STG = QW + 1;

   logic [STG-1:0] vld_ff;
   logic [STG-1:0] miss_ff;
   logic [STG-1:0] sat_ff;
   logic [NW-1:0]  rem_ff [STG];
   logic [DW-1:0]  dabs_ff [STG];
   logic [QW-1:0]  quo_ff [STG];

   logic [QW-1:0]    tq;
   logic             hit_in;
   logic             strobe_ff;
   rti_pkg::rsp_type rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      miss_ff[0] <= in_entry.miss;
      sat_ff[0]  <= in_entry.sat;
      rem_ff[0]  <= NW'(in_entry.tn) << FRAC_BITS;
      dabs_ff[0] <= in_entry.dabs;
      quo_ff[0]  <= '0;
   end

   for (genvar s = 0; s < QW; s++) begin : g_div
      localparam int B = QW - 1 - s;
      logic [NW-1:0] d;
      logic          ge;

      assign d  = NW'(dabs_ff[s]) << B;
      assign ge = (rem_ff[s] >= d);

      always_ff @(posedge clock) begin
         miss_ff[s+1] <= miss_ff[s];
         sat_ff[s+1]  <= sat_ff[s];
         dabs_ff[s+1] <= dabs_ff[s];
         rem_ff[s+1]  <= ge ? rem_ff[s] - d : rem_ff[s];
         quo_ff[s+1]  <= ge ? (quo_ff[s] | (QW'(1) << B)) : quo_ff[s];
      end
   end

   always_comb begin
      tq              = sat_ff[QW] ? '1 : quo_ff[QW];
      hit_in          = !miss_ff[QW] && (tq > eps);
      rsp_in.hit      = hit_in;
      rsp_in.distance = hit_in ? tq : '0;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         vld_ff    <= {vld_ff[STG-2:0], in_valid};
         strobe_ff <= vld_ff[STG-1];
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// File: verif/ray_triangle_intersect_unit_tb.sv
// Testbench for ray_triangle_intersect_unit: streams triangles against several ray
// settings and checks every hit/distance result against an exact fixed-point predictor.
// Depends on rti_pkg and the unit RTL only.
`default_nettype none

module ray_triangle_intersect_unit_tb;

   typedef logic signed [255:0] wide_type;

   class intersect_checker;
      rti_pkg::rsp_type pending_hits[$];
      logic [31:0] origin[3];
      logic [31:0] dir[3];
      logic [30:0] eps;
      int         errors;
      int         hits;
      int         misses;

      function new();
         origin = '{32'd0, 32'd0, 32'd0};
         dir = '{32'd0, 32'd0, 32'h0001_0000};
         eps = 31'd1;
      endfunction

      function rti_pkg::rsp_type compute_hit(rti_pkg::req_type r);
         wide_type o[3], d[3], v[3], a[3], b[3], p[3], tv[3], q[3];
         wide_type det, dabs, un, vn, tn, num, tq;
         rti_pkg::rsp_type res;
         res = '0;
         for (int k = 0; k < 3; k++) begin
            o[k] = $signed(origin[k]);
            d[k] = $signed(dir[k]);
         end
         v[0] = $signed(r.vert_x);   v[1] = $signed(r.vert_y);   v[2] = $signed(r.vert_z);
         a[0] = $signed(r.edge_a_x); a[1] = $signed(r.edge_a_y); a[2] = $signed(r.edge_a_z);
         b[0] = $signed(r.edge_b_x); b[1] = $signed(r.edge_b_y); b[2] = $signed(r.edge_b_z);
         p[0] = d[1] * b[2] - d[2] * b[1];
         p[1] = d[2] * b[0] - d[0] * b[2];
         p[2] = d[0] * b[1] - d[1] * b[0];
         det = a[0] * p[0] + a[1] * p[1] + a[2] * p[2];
         dabs = (det < 0) ? -det : det;
         if (dabs < (wide_type'(eps) <<< 32) || dabs == 0) return res;
         for (int k = 0; k < 3; k++) tv[k] = o[k] - v[k];
         un = tv[0] * p[0] + tv[1] * p[1] + tv[2] * p[2];
         q[0] = tv[1] * a[2] - tv[2] * a[1];
         q[1] = tv[2] * a[0] - tv[0] * a[2];
         q[2] = tv[0] * a[1] - tv[1] * a[0];
         vn = d[0] * q[0] + d[1] * q[1] + d[2] * q[2];
         tn = b[0] * q[0] + b[1] * q[1] + b[2] * q[2];
         if (det < 0) begin
            un = -un;
            vn = -vn;
            tn = -tn;
         end
         if (un < 0 || un > dabs) return res;
         if (vn < 0 || un + vn > dabs) return res;
         if (tn <= 0) return res;
         num = tn <<< 16;
         if (num >= (dabs <<< 31)) tq = 256'h7FFF_FFFF;
         else tq = num / dabs;
         if (tq > wide_type'(eps)) begin
            res.hit = 1'b1;
            res.distance = tq[30:0];
         end
         return res;
      endfunction

      function void note_transfer(rti_pkg::req_type r);
         pending_hits.push_back(compute_hit(r));
      endfunction

      function void check_result(rti_pkg::rsp_type got);
         rti_pkg::rsp_type want;
         if (pending_hits.size() == 0) begin
            $display("%0t: unexpected result hit=%0b distance=%0h", $time, got.hit,
                     got.distance);
            errors++;
            return;
         end
         want = pending_hits.pop_front();
         if (want.hit) hits++;
         else misses++;
         if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, got.hit);
            errors++;
         end
         if (got.distance !== want.distance) begin
            $display("%0t: distance expected %0h actual %0h", $time, want.distance,
                     got.distance);
            errors++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   rti_pkg::req_type               req_item;
   logic                           rsp_strobe;
   rti_pkg::rsp_type               rsp_item;
   logic                           csr_we;
   logic [rti_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rti_pkg::COORD_W-1:0]    csr_wdata;

   intersect_checker sb;
   bit               idle_enable;
   int               sent;

   ray_triangle_intersect_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   function automatic rti_pkg::req_type tri_units(int vx, int vy, int vz, int ax, int ay,
                                                  int az, int bx, int by, int bz);
      rti_pkg::req_type r;
      r.vert_x = vx <<< 16;   r.vert_y = vy <<< 16;   r.vert_z = vz <<< 16;
      r.edge_a_x = ax <<< 16; r.edge_a_y = ay <<< 16; r.edge_a_z = az <<< 16;
      r.edge_b_x = bx <<< 16; r.edge_b_y = by <<< 16; r.edge_b_z = bz <<< 16;
      return r;
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         4: return 32'h1;
         default: return $urandom;
      endcase
   endfunction

   // aim a triangle so the ray meets its plane at a chosen t, u, v, which may lie outside it
   function automatic rti_pkg::req_type aimed_triangle();
      rti_pkg::req_type r;
      longint e1[3], e2[3], pt, v0;
      int u, v, t;
      u = $urandom_range(0, 300) - 20;
      v = $urandom_range(0, 300) - 20;
      t = $urandom_range(0, 20);
      for (int k = 0; k < 3; k++) begin
         e1[k] = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
         e2[k] = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
      end
      for (int k = 0; k < 3; k++) begin
         pt = longint'($signed(sb.origin[k])) + longint'($signed(sb.dir[k])) * t;
         v0 = pt - (e1[k] * u + e2[k] * v) / 256;
         case (k)
            0: begin
               r.vert_x = v0[31:0]; r.edge_a_x = e1[0][31:0]; r.edge_b_x = e2[0][31:0];
            end
            1: begin
               r.vert_y = v0[31:0]; r.edge_a_y = e1[1][31:0]; r.edge_b_y = e2[1][31:0];
            end
            default: begin
               r.vert_z = v0[31:0]; r.edge_a_z = e1[2][31:0]; r.edge_b_z = e2[2][31:0];
            end
         endcase
      end
      return r;
   endfunction

   function automatic rti_pkg::req_type random_triangle();
      rti_pkg::req_type r;
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return aimed_triangle();
      if (sel < 85) begin
         r = '0;
         r.vert_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.vert_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.vert_z = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.edge_a_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.edge_a_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.edge_a_z = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.edge_b_x = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.edge_b_y = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         r.edge_b_z = $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         return r;
      end
      if (sel < 95) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
         return r;
      end
      r = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
           pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
      return r;
   endfunction

   task automatic send_triangle(rti_pkg::req_type r);
      int gap;
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      sb.note_transfer(r);
      sent++;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_hits.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                          logic [30:0] e);
      logic [rti_pkg::CSR_IDX_W-1:0] idx[7];
      logic [31:0] val[7];
      idx = '{rti_pkg::CSR_ORIGIN_X, rti_pkg::CSR_ORIGIN_Y, rti_pkg::CSR_ORIGIN_Z,
              rti_pkg::CSR_DIR_X, rti_pkg::CSR_DIR_Y, rti_pkg::CSR_DIR_Z,
              rti_pkg::CSR_EPSILON};
      val = '{ox, oy, oz, dx, dy, dz, {1'b0, e}};
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      sb.origin = '{ox, oy, oz};
      sb.dir = '{dx, dy, dz};
      sb.eps = e;
   endtask

   task automatic random_burst(int count);
      for (int i = 0; i < count; i++) send_triangle(random_triangle());
   endtask

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      sb = new();
      sent = 0;
      idle_enable = 1'b1;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      csr_we <= 1'b0;
      csr_index <= rti_pkg::CSR_ORIGIN_X;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_triangle('0);
      send_triangle({9{32'h7FFF_FFFF}});
      send_triangle({9{32'h8000_0000}});
      send_triangle({9{32'hFFFF_FFFF}});
      send_triangle(tri_units(-1, -1, 5, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(-1, -1, 5, 0, 3, 0, 3, 0, 0));
      send_triangle(tri_units(-1, -1, -5, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(1, -1, 5, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(-1, 1, 5, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(1, 1, 5, -3, 0, 0, 0, -3, 0));
      send_triangle(tri_units(0, 0, 5, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(-1, 0, 5, 1, 0, 0, 0, 1, 0));
      send_triangle(tri_units(-1, -1, 5, 3, 0, 1, 0, 0, 3));
      send_triangle(tri_units(-1, -1, 32767, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(-1, -1, 0, 3, 0, 0, 0, 3, 0));
      random_burst(150);
      drain();

      set_ray(32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000, 32'h0000_1999, 32'h0000_3333,
              32'h0001_0000, 31'd1);
      random_burst(170);
      drain();

      set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 31'd0);
      send_triangle(tri_units(-1, -1, 5, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(0, 0, 5, 3, 0, 0, 0, 3, 0));
      send_triangle(tri_units(-1, -1, 5, 3, 0, 0, 3, 0, 0));
      random_burst(150);
      drain();

      set_ray(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 31'h7FFF_FFFF);
      random_burst(120);
      drain();

      set_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 31'd65536);
      random_burst(150);
      drain();

      set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              31'($urandom_range(0, 1 << 18)));
      random_burst(150);
      drain();

      idle_enable = 1'b0;
      set_ray(32'hFFFF_0000, 32'h0000_8000, 32'hFFF6_0000, 32'h0000_0800, 32'hFFFF_F000,
              32'h0002_0000, 31'd16);
      random_burst(300);
      drain();

      $display("Covered %0d triangles over seven ray settings: %0d hits, %0d misses.",
               sent, sb.hits, sb.misses);
      if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
